// ===== sv/bbd_pkg.sv =====
package bbd_pkg;

  // field widths fixed by the register and payload formats
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int SHIFT_W  = 3;
  localparam int CFG_IDX_W = 2;

  // counter widths: column byte up to 3*4095+2, pixel up to 4095
  localparam int COL_W = 14;
  localparam int PIX_W = 12;
  localparam int ROW_W = 13;

  // accumulator index wide enough for 3*8192 entries
  localparam int OP_IDX_W = 15;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd1;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1;
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SHRINK_SHIFT = 2'd2
  } cfg_idx_t;

  // one accumulate operation on a column sum
  typedef struct packed {
    logic [OP_IDX_W-1:0] idx;
    logic [7:0]          data;
    logic                first;
    logic                emit;
    logic [1:0]          pad;
    logic                frame_end;
  } op_t;

  // one run of results: averaged byte plus its row padding
  typedef struct packed {
    logic [7:0] avg;
    logic [1:0] pad;
    logic       frame_end;
  } res_t;

endpackage

// ===== sv/bbd_front.sv =====
module bbd_front import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SHIFT  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [WIDTH_W-1:0]  image_width,
  input  logic [HEIGHT_W-1:0] image_height,
  input  logic [SHIFT_W-1:0]  shrink_shift,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                push,
  output op_t                 push_op,
  output logic [SHIFT_W-1:0]  k_eff
);

  logic [COL_W-1:0]    c_r, c_nxt;
  logic [PIX_W-1:0]    p_r, p_nxt;
  logic [1:0]          ch_r, ch_nxt;
  logic [ROW_W-1:0]    r_r, r_nxt;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    rowbytes, rowlen, obytes, c_inc;
  logic [1:0]          pad_in, pad_out;
  logic [PIX_W-1:0]    wout, bx, px;
  logic [ROW_W-1:0]    hout, by, ry;
  logic [ROW_W:0]      r_inc;
  logic [7:0]          side_m1;
  logic                in_block, row_end, accept;

  // clamp the registers to the supported range
  always_comb begin
    priority if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    priority if (image_height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    if (32'(shrink_shift) > MAX_SHIFT) begin
      k_eff = SHIFT_W'(MAX_SHIFT);
    end else begin
      k_eff = shrink_shift;
    end
  end

  assign rowbytes = COL_W'({w_eff, 1'b0}) + COL_W'(w_eff);
  assign pad_in   = 2'(3'd4 - {1'b0, rowbytes[1:0]});
  assign rowlen   = rowbytes + COL_W'(pad_in);
  assign wout     = PIX_W'(w_eff >> k_eff);
  assign hout     = ROW_W'(h_eff >> k_eff);
  assign obytes   = COL_W'({wout, 1'b0}) + COL_W'(wout);
  assign pad_out  = 2'(3'd4 - {1'b0, obytes[1:0]});
  assign side_m1  = 8'((9'd1 << k_eff) - 9'd1);

  assign bx = p_r >> k_eff;
  assign by = r_r >> k_eff;
  assign px = p_r & PIX_W'(side_m1);
  assign ry = r_r & ROW_W'(side_m1);

  assign in_block = (c_r < rowbytes) && (bx < wout) && (by < hout);
  assign row_end  = (bx == wout - PIX_W'(1)) && (ch_r == 2'd2);

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && in_block;

  always_comb begin
    push_op.idx       = OP_IDX_W'({bx, 1'b0}) + OP_IDX_W'(bx) + OP_IDX_W'(ch_r);
    push_op.data      = in_byte;
    push_op.first     = (px == '0) && (ry == '0);
    push_op.emit      = (px == PIX_W'(side_m1)) && (ry == ROW_W'(side_m1));
    push_op.pad       = row_end ? pad_out : 2'd0;
    push_op.frame_end = row_end && (by == hout - ROW_W'(1));
  end

  // raster position; pixel and channel track the column byte without a divide
  always_comb begin
    c_inc = c_r + COL_W'(1);
    r_inc = {1'b0, r_r} + (ROW_W+1)'(1);
    if (c_inc >= rowlen) begin
      c_nxt  = '0;
      p_nxt  = '0;
      ch_nxt = 2'd0;
      r_nxt  = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      c_nxt = c_inc;
      if (ch_r == 2'd2) begin
        ch_nxt = 2'd0;
        p_nxt  = p_r + PIX_W'(1);
      end else begin
        ch_nxt = ch_r + 2'd1;
        p_nxt  = p_r;
      end
      r_nxt = (r_r >= h_eff) ? '0 : r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r  <= '0;
      p_r  <= '0;
      ch_r <= 2'd0;
      r_r  <= '0;
    end else if (accept) begin
      c_r  <= c_nxt;
      p_r  <= p_nxt;
      ch_r <= ch_nxt;
      r_r  <= r_nxt;
    end
  end

endmodule

// ===== sv/bbd_queue.sv =====
module bbd_queue import bbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic valid,
  output op_t  head,
  input  logic pop
);

  op_t               entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_pop;

  assign full   = (count_r == (QPTR_W+1)'(QDEPTH));
  assign valid  = (count_r != '0);
  assign head   = entries_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/bbd_back.sv =====
module bbd_back import bbd_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SHIFT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SHIFT_W-1:0] k_eff,
  input  logic               q_valid,
  input  op_t                q_op,
  output logic               q_pop,
  output logic               res_valid,
  output res_t               res,
  input  logic               res_ready
);

  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int SUM_W = 8 + 2 * MAX_SHIFT;

  logic [SUM_W-1:0] sums_r [DEPTH];
  logic [SUM_W-1:0] rdata_r;
  op_t              s2_op_r;
  logic             s2_valid_r;
  logic             lw_valid_r;
  logic [IDXW-1:0]  lw_idx_r;
  logic [SUM_W-1:0] lw_val_r;

  logic             s2_go;
  logic [IDXW-1:0]  s2_idx;
  logic [SUM_W-1:0] operand, sum;

  assign s2_idx = s2_op_r.idx[IDXW-1:0];
  assign s2_go  = s2_valid_r && (!s2_op_r.emit || res_ready);
  assign q_pop  = q_valid && (!s2_valid_r || s2_go);

  // the write that lands on the read edge is not in rdata_r, take it from lw
  always_comb begin
    if (s2_op_r.first) begin
      operand = '0;
    end else if (lw_valid_r && (lw_idx_r == s2_idx)) begin
      operand = lw_val_r;
    end else begin
      operand = rdata_r;
    end
  end

  assign sum = operand + SUM_W'(s2_op_r.data);

  assign res_valid     = s2_valid_r && s2_op_r.emit;
  assign res.avg       = 8'(sum >> {k_eff, 1'b0});
  assign res.pad       = s2_op_r.pad;
  assign res.frame_end = s2_op_r.frame_end;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rdata_r <= sums_r[q_op.idx[IDXW-1:0]];
      s2_op_r <= q_op;
    end
    if (s2_go) begin
      sums_r[s2_idx] <= sum;
      lw_idx_r       <= s2_idx;
      lw_val_r       <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      lw_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s2_valid_r <= 1'b1;
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_go) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/bbd_out.sv =====
module bbd_out import bbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  input  res_t       res,
  output logic       res_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_padding,
  output logic       out_last_of_run,
  output logic       out_end_of_frame
);

  logic       busy_r;
  logic [7:0] avg_r;
  logic [1:0] pad_r;
  logic [1:0] pos_r;
  logic       eof_r;
  logic       accept, last;

  assign last             = (pos_r == pad_r);
  assign accept           = busy_r && !out_stall;
  assign res_ready        = !busy_r || (accept && last);

  assign out_valid        = busy_r;
  assign out_byte         = (pos_r == 2'd0) ? avg_r : 8'd0;
  assign out_is_padding   = (pos_r != 2'd0);
  assign out_last_of_run  = last;
  assign out_end_of_frame = last && eof_r;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      avg_r <= res.avg;
      pad_r <= res.pad;
      eof_r <= res.frame_end;
    end
  end

  // pos counts the word within the run: averaged byte first, then padding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 2'd0;
    end else if (res_valid && res_ready) begin
      busy_r <= 1'b1;
      pos_r  <= 2'd0;
    end else if (accept) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= pos_r + 2'd1;
      end
    end
  end

endmodule

// ===== sv/bmp_box_downscale.sv =====
// path: an accepted byte is registered in the queue, the read stage and the output register
// throughput: one byte per cycle unless stalled; one column-sum read-modify-write per block byte
// output: one word per cycle unless stalled; a row-ending byte is followed by its row padding
// reset: synchronous active-low rst_n clears position counters, queue, pipeline and
// registers (width 1, height 1, shift 1); the column-sum store is not cleared
module bmp_box_downscale import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SHIFT  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_is_padding,
  output logic                 out_last_of_run,
  output logic                 out_end_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HEIGHT_W-1:0]  cfg_data
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic [SHIFT_W-1:0]  k_eff;

  logic push, q_full, q_valid, q_pop;
  op_t  push_op, q_head;
  logic res_valid, res_ready;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      shift_r  <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        CFG_SHRINK_SHIFT: shift_r  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  bbd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_SHIFT  (MAX_SHIFT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .shrink_shift (shift_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op),
    .k_eff        (k_eff)
  );

  bbd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head),
    .pop     (q_pop)
  );

  bbd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SHIFT (MAX_SHIFT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .k_eff     (k_eff),
    .q_valid   (q_valid),
    .q_op      (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  bbd_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .res_ready        (res_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_is_padding   (out_is_padding),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// ===== sv/bbd_checker.sv =====
module bbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_is_padding,
  input logic       out_last_of_run,
  input logic       out_end_of_frame
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_is_padding)
      && $stable(out_last_of_run) && $stable(out_end_of_frame))
    else $error("stalled output word changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_padding |-> out_byte == 8'd0)
    else $error("padding word is not zero");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_last_of_run)
    else $error("end of frame not on last word of run");

  // the rest of a run is padding and follows without a gap
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid && out_is_padding)
    else $error("run broken before its last word");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind bmp_box_downscale bbd_checker u_bbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_byte         (out_byte),
  .out_is_padding   (out_is_padding),
  .out_last_of_run  (out_last_of_run),
  .out_end_of_frame (out_end_of_frame)
);
